// ===== design/dfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, codes, payload types and a buffer address helper for the
// delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int BUF_BYTES = 64;
  localparam int AW        = $clog2(BUF_BYTES);
  localparam int CW        = $clog2(BUF_BYTES + 1);

  localparam int FRAME_LEN = 25;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_SUM_HI = IDX_W'(21);

  localparam logic [7:0] MARK_START   = 8'h53;
  localparam logic [7:0] MARK_END     = 8'h45;
  localparam logic [7:0] CMD_SETTINGS = 8'd8;
  localparam logic [7:0] CMD_DATA_A   = 8'd2;
  localparam logic [7:0] CMD_DATA_B   = 8'd4;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_SHORT = 3'd1;
  localparam logic [2:0] ERR_ADDR  = 3'd2;
  localparam logic [2:0] ERR_SUM   = 3'd3;
  localparam logic [2:0] ERR_CMD   = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [15:0] expected_id;
    logic        settings_mode;
  } item_t;

  typedef struct packed {
    logic        frame_ok;
    logic [2:0]  err_code;
    logic        was_settings;
    logic [7:0]  fet_temp;
    logic [7:0]  coil_temp;
    logic [15:0] batt_voltage;
    logic [15:0] batt_current;
    logic [15:0] panel_voltage;
    logic [15:0] ev_target_value;
    logic [7:0]  duty_percent;
    logic [15:0] vmp_setting;
    logic [7:0]  charge_limit_pct;
  } result_t;

  typedef struct packed {
    logic          start;
    logic [CW-1:0] count;
    logic [AW-1:0] head;
    logic [15:0]   want_id;
    logic          mode;
  } scan_req_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } scan_stat_t;

  // Reduces a sum of two buffer positions, known to stay below twice the
  // buffer size, to a physical address.
  function automatic logic [AW-1:0] buf_wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= (AW+1)'(BUF_BYTES)) ? s - (AW+1)'(BUF_BYTES) : s;
    return t[AW-1:0];
  endfunction

endpackage

// ===== design/dfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dfr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dfr_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_scan
// Frame search engine: walks the candidate start positions of the buffer in
// order until a frame passes, reads up to the 25 frame bytes through the RAM
// read port and checks delimiters, command, checksum and sender address.
// ----------------------------------------------------------------------------
module dfr_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  dfr_pkg::scan_req_t     req,
  input  logic                   take,
  input  logic [7:0]             rdata,
  output logic                   rd_en,
  output logic [dfr_pkg::AW-1:0] rd_addr,
  output dfr_pkg::scan_stat_t    stat,
  output dfr_pkg::result_t       res
);

  import dfr_pkg::*;

  localparam int NXT_W = CW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PROC = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [AW-1:0]    base;
  logic [AW-1:0]    pos;
  logic [IDX_W-1:0] idx;
  logic [15:0]      sum;
  logic [2:0]       err;
  logic [7:0]       frm [FRAME_LEN];

  logic [NXT_W-1:0] nb;
  logic             more;
  logic             cmd_ok;
  logic             sum_ok;
  logic             addr_ok;
  logic [2:0]       err_eval;
  result_t          res_short;
  result_t          res_fail;
  result_t          res_pass;

  assign nb   = NXT_W'(base) + NXT_W'(1);
  assign more = (nb + NXT_W'(FRAME_LEN)) <= NXT_W'(req.count);

  assign cmd_ok  = req.mode ? (frm[5] == CMD_SETTINGS)
                            : (frm[5] == CMD_DATA_A || frm[5] == CMD_DATA_B);
  assign sum_ok  = sum == {frm[22], frm[23]};
  assign addr_ok = {frm[3], frm[4]} == req.want_id;

  // The first failing check in command, checksum, address order.
  assign err_eval = !cmd_ok ? ERR_CMD : (!sum_ok ? ERR_SUM : ERR_ADDR);

  always_comb begin
    res_short              = '0;
    res_short.err_code     = ERR_SHORT;
    res_short.was_settings = req.mode;

    res_fail              = '0;
    res_fail.err_code     = (state == S_EVAL) ? err_eval : err;
    res_fail.was_settings = req.mode;

    res_pass              = '0;
    res_pass.frame_ok     = 1'b1;
    res_pass.err_code     = ERR_OK;
    res_pass.was_settings = req.mode;
    if (req.mode) begin
      res_pass.vmp_setting      = {frm[16], frm[17]};
      res_pass.charge_limit_pct = frm[21];
    end else begin
      res_pass.fet_temp        = frm[7];
      res_pass.coil_temp       = frm[8];
      res_pass.batt_voltage    = {frm[9], frm[10]};
      res_pass.batt_current    = {frm[11], frm[12]};
      res_pass.panel_voltage   = {frm[13], frm[14]};
      res_pass.ev_target_value = {frm[15], frm[16]};
      res_pass.duty_percent    = frm[17];
    end
  end

  assign rd_en          = (state == S_RD);
  assign rd_addr        = buf_wrap({1'b0, req.head} + {1'b0, pos});
  assign stat.busy      = (state != S_IDLE);
  assign stat.res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            if (req.count < CW'(FRAME_LEN)) begin
              res   <= res_short;
              state <= S_DONE;
            end else begin
              base  <= '0;
              pos   <= '0;
              idx   <= '0;
              sum   <= '0;
              err   <= ERR_SHORT;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_PROC;
        end
        S_PROC: begin
          frm[idx] <= rdata;
          if (idx != '0 && idx <= IDX_SUM_HI) begin
            sum <= sum + 16'(rdata);
          end
          if ((idx == '0 && rdata != MARK_START) ||
              (idx == IDX_LAST && rdata != MARK_END)) begin
            // Not a delimited frame at this position; try the next one.
            if (more) begin
              base  <= nb[AW-1:0];
              pos   <= nb[AW-1:0];
              idx   <= '0;
              sum   <= '0;
              state <= S_RD;
            end else begin
              res   <= res_fail;
              state <= S_DONE;
            end
          end else if (idx == IDX_LAST) begin
            state <= S_EVAL;
          end else begin
            idx   <= idx + IDX_W'(1);
            pos   <= pos + AW'(1);
            state <= S_RD;
          end
        end
        S_EVAL: begin
          if (cmd_ok && sum_ok && addr_ok) begin
            res   <= res_pass;
            state <= S_DONE;
          end else begin
            err <= err_eval;
            if (more) begin
              base  <= nb[AW-1:0];
              pos   <= nb[AW-1:0];
              idx   <= '0;
              sum   <= '0;
              state <= S_RD;
            end else begin
              res   <= res_fail;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Every read issued is consumed in the following cycle.
  a_rd_then_proc: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> state == S_PROC)
    else $error("read data not consumed after issue");

  // Reads never leave the valid part of the buffer.
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> NXT_W'(pos) < NXT_W'(req.count))
    else $error("scan read beyond byte count");

  // A new scan is only requested while the engine is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == S_IDLE)
    else $error("scan requested while busy");

  // A finished result flags success exactly when its error code is clear.
  a_res_consistent: assert property (@(posedge clk) disable iff (rst)
    stat.res_valid |-> (res.frame_ok == (res.err_code == ERR_OK)))
    else $error("result flag and error code disagree");
`endif

endmodule

// ===== design/delimited_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Receives bytes into a circular buffer and, on an end request, searches it
// for a start/end delimited 25-byte frame with a 16-bit sum check.
// ----------------------------------------------------------------------------
// Start and byte requests are taken back to back while no end request occupies
// the block; a byte goes straight into the circular buffer RAM, and once the
// buffer is full the oldest byte is overwritten by moving the head pointer. An
// end request occupies the block until its result has been handed to the
// output register, which waits while that register is still stalled: a short
// buffer has its result set directly, otherwise the search visits the candidate
// frame positions in order until one passes, reading the bytes one at a time
// through the single RAM read port and moving on as soon as a delimiter fails.
// The buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module delimited_frame_receiver (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dfr_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output dfr_pkg::result_t  result
);

  import dfr_pkg::*;

  logic [CW-1:0] byte_count;
  logic [AW-1:0] head;
  logic [15:0]   want_id;
  logic          mode_settings;

  logic          acc;
  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          take;
  scan_req_t     sreq;
  scan_stat_t    sstat;
  result_t       sres;

  assign item_stall = sstat.busy;
  assign acc        = item_valid && !item_stall;
  assign full       = (byte_count == CW'(BUF_BYTES));
  assign wr_en      = acc && (item.op == OP_BYTE);
  assign wr_addr    = full ? head : buf_wrap({1'b0, head} + {1'b0, byte_count[AW-1:0]});

  assign sreq.start   = acc && (item.op == OP_END);
  assign sreq.count   = byte_count;
  assign sreq.head    = head;
  assign sreq.want_id = want_id;
  assign sreq.mode    = mode_settings;

  // The finished result moves to the output register once that is free.
  assign take = sstat.res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      head          <= '0;
      want_id       <= '0;
      mode_settings <= 1'b0;
    end else if (acc) begin
      case (item.op)
        OP_START: begin
          byte_count    <= '0;
          want_id       <= item.expected_id;
          mode_settings <= item.settings_mode;
        end
        OP_BYTE: begin
          if (full) begin
            head <= buf_wrap({1'b0, head} + (AW+1)'(1));
          end else begin
            byte_count <= byte_count + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= sres;
    end
  end

  dfr_ram #(
    .DEPTH (BUF_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.data_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dfr_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .take    (take),
    .rdata   (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .stat    (sstat),
    .res     (sres)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delimited frame receiver. A short directed
// part is followed by random start/byte/end sequences. Most of these carry
// well-formed frames, some of them with one fault injected. A shadow of the
// receive buffer predicts the result of every end request, and each result
// is compared field by field. Both handshakes idle at random, and one long
// output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import dfr_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // not decoded by the block
  localparam int ITEMS_TARGET    = 1150;
  localparam int MIN_SCANS       = 48;
  localparam int GAP_PCT         = 38;
  localparam int HOLD_CYCLES     = 600;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 2100;
  localparam int MAX_REPORTS     = 10;

  typedef enum int {FAULT_NONE, FAULT_CMD, FAULT_SUM, FAULT_ADDR, FAULT_MARK} frame_fault_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // Shadow of the receiver state.
  logic [7:0]  rx_bytes [BUF_BYTES];
  int          rx_count;
  logic [15:0] rx_want_id;
  logic        rx_mode;
  result_t     pending_scans [$];

  int gap_pct = GAP_PCT;
  bit hold_pending;
  int hold_left;
  int idle_cycles;
  int items_sent;
  int scans_sent;
  int results_checked;
  int mismatches;

  delimited_frame_receiver uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic result_t predict_scan();
    result_t     r;
    logic [7:0]  fr [FRAME_LEN];
    logic [15:0] sum;
    logic [2:0]  err;
    bit          found;
    r = '0;
    r.was_settings = rx_mode;
    err = ERR_SHORT;
    found = 1'b0;
    if (rx_count < FRAME_LEN) begin
      r.err_code = ERR_SHORT;
      return r;
    end
    for (int e = FRAME_LEN - 1; e < rx_count && !found; e++) begin
      if (rx_bytes[e] == MARK_END && rx_bytes[e - FRAME_LEN + 1] == MARK_START) begin
        for (int i = 0; i < FRAME_LEN; i++) fr[i] = rx_bytes[e - FRAME_LEN + 1 + i];
        sum = '0;
        for (int i = 1; i <= 21; i++) sum += fr[i];
        if (rx_mode ? (fr[5] != CMD_SETTINGS)
                    : (fr[5] != CMD_DATA_A && fr[5] != CMD_DATA_B)) begin
          err = ERR_CMD;
        end else if (sum != {fr[22], fr[23]}) begin
          err = ERR_SUM;
        end else if ({fr[3], fr[4]} != rx_want_id) begin
          err = ERR_ADDR;
        end else begin
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      r.err_code = err;
      return r;
    end
    r.frame_ok = 1'b1;
    r.err_code = ERR_OK;
    if (rx_mode) begin
      r.vmp_setting      = {fr[16], fr[17]};
      r.charge_limit_pct = fr[21];
    end else begin
      r.fet_temp        = fr[7];
      r.coil_temp       = fr[8];
      r.batt_voltage    = {fr[9], fr[10]};
      r.batt_current    = {fr[11], fr[12]};
      r.panel_voltage   = {fr[13], fr[14]};
      r.ev_target_value = {fr[15], fr[16]};
      r.duty_percent    = fr[17];
    end
    return r;
  endfunction

  task automatic track_request(input item_t it);
    case (it.op)
      OP_START: begin
        rx_count   = 0;
        rx_want_id = it.expected_id;
        rx_mode    = it.settings_mode;
      end
      OP_BYTE: begin
        if (rx_count < BUF_BYTES) begin
          rx_bytes[rx_count] = it.data_byte;
          rx_count++;
        end else begin
          for (int i = 0; i < BUF_BYTES - 1; i++) rx_bytes[i] = rx_bytes[i + 1];
          rx_bytes[BUF_BYTES - 1] = it.data_byte;
        end
      end
      OP_END: begin
        pending_scans.push_back(predict_scan());
        scans_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] result %0d:%s expected %h got %h", $realtime, results_checked, what,
               want, got);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    string   bad;
    if (pending_scans.size() == 0) begin
      report_mismatch(" unexpected result,", '0, got);
      return;
    end
    want = pending_scans.pop_front();
    bad = "";
    if (got.frame_ok !== want.frame_ok)                 bad = {bad, " frame_ok"};
    if (got.err_code !== want.err_code)                 bad = {bad, " err_code"};
    if (got.was_settings !== want.was_settings)         bad = {bad, " was_settings"};
    if (got.fet_temp !== want.fet_temp)                 bad = {bad, " fet_temp"};
    if (got.coil_temp !== want.coil_temp)               bad = {bad, " coil_temp"};
    if (got.batt_voltage !== want.batt_voltage)         bad = {bad, " batt_voltage"};
    if (got.batt_current !== want.batt_current)         bad = {bad, " batt_current"};
    if (got.panel_voltage !== want.panel_voltage)       bad = {bad, " panel_voltage"};
    if (got.ev_target_value !== want.ev_target_value)   bad = {bad, " ev_target_value"};
    if (got.duty_percent !== want.duty_percent)         bad = {bad, " duty_percent"};
    if (got.vmp_setting !== want.vmp_setting)           bad = {bad, " vmp_setting"};
    if (got.charge_limit_pct !== want.charge_limit_pct) bad = {bad, " charge_limit_pct"};
    if (bad != "") report_mismatch({bad, " differ,"}, want, got);
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
  end

  // Output stall: random, or held high for a counted stretch on request.
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_left = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request or result accepted for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The request stays on the bus until the block takes it.
  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    track_request(it);
    if (it.op != OP_NONE) items_sent++;
  endtask

  function automatic item_t make_item(input logic [1:0] op);
    item_t it;
    it.op            = op;
    it.data_byte     = 8'($urandom_range(255));
    it.expected_id   = 16'($urandom_range(65535));
    it.settings_mode = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_op(input logic [1:0] op);
    send_item(make_item(op));
  endtask

  task automatic send_start(input logic [15:0] id, input logic mode);
    item_t it;
    it = make_item(OP_START);
    it.expected_id   = id;
    it.settings_mode = mode;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it = make_item(OP_BYTE);
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_frame(input logic [15:0] id, input logic mode, input frame_fault_t fault,
                            input bit random_fill, input logic [7:0] fill);
    logic [7:0]  fr [FRAME_LEN];
    logic [15:0] sum;
    for (int i = 0; i < FRAME_LEN; i++) fr[i] = random_fill ? 8'($urandom_range(255)) : fill;
    fr[0]  = MARK_START;
    fr[24] = MARK_END;
    fr[3]  = id[15:8];
    fr[4]  = id[7:0];
    if (mode) fr[5] = CMD_SETTINGS;
    else fr[5] = $urandom_range(1) ? CMD_DATA_A : CMD_DATA_B;
    if (fault == FAULT_CMD) begin
      // Half the time use a command that is valid for the other mode.
      if ($urandom_range(1)) begin
        fr[5] = mode ? CMD_DATA_B : CMD_SETTINGS;
      end else begin
        do fr[5] = 8'($urandom_range(255));
        while (mode ? fr[5] == CMD_SETTINGS : (fr[5] == CMD_DATA_A || fr[5] == CMD_DATA_B));
      end
    end
    if (fault == FAULT_ADDR) fr[3 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
    sum = '0;
    for (int i = 1; i <= 21; i++) sum += fr[i];
    fr[22] = sum[15:8];
    fr[23] = sum[7:0];
    if (fault == FAULT_SUM) fr[22 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
    if (fault == FAULT_MARK) begin
      if ($urandom_range(1)) fr[0] ^= 8'($urandom_range(1, 255));
      else fr[24] ^= 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < FRAME_LEN; i++) send_byte(fr[i]);
  endtask

  function automatic frame_fault_t pick_fault();
    int r;
    r = $urandom_range(99);
    if (r < 40) return FAULT_NONE;
    if (r < 55) return FAULT_CMD;
    if (r < 70) return FAULT_SUM;
    if (r < 85) return FAULT_ADDR;
    return FAULT_MARK;
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_random_sequence();
    int          kind;
    int          noise;
    logic [15:0] id;
    logic        mode;
    kind = $urandom_range(99);
    id   = pick_id();
    mode = 1'($urandom_range(1));
    if (kind < 65) begin
      // A framed reception; leading noise sometimes overflows the buffer.
      send_start(id, mode);
      noise = ($urandom_range(4) == 0) ? $urandom_range(45) : $urandom_range(6);
      repeat (noise) send_byte(8'($urandom_range(255)));
      send_frame(id, mode, pick_fault(), 1'b1, 8'h00);
      if ($urandom_range(9) < 3) send_frame(id, mode, pick_fault(), 1'b1, 8'h00);
      repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
      send_op(OP_END);
      if ($urandom_range(9) == 0) send_op(OP_END);
    end else if (kind < 82) begin
      send_start(id, mode);
      repeat ($urandom_range(FRAME_LEN - 1)) send_byte(8'($urandom_range(255)));
      send_op(OP_END);
    end else if (kind < 95) begin
      // Unframed traffic on top of whatever the buffer holds.
      repeat ($urandom_range(8, 30)) begin
        noise = $urandom_range(99);
        if (noise < 70) send_byte(8'($urandom_range(255)));
        else if (noise < 85) send_op(OP_NONE);
        else if (noise < 95) send_op(OP_START);
        else send_op(OP_END);
      end
      send_op(OP_END);
    end else begin
      send_op(OP_END);
    end
  endtask

  task automatic test_directed();
    send_op(OP_END);  // empty buffer right after reset
    send_op(OP_NONE);
    send_start(16'hFFFF, 1'b1);
    send_frame(16'hFFFF, 1'b1, FAULT_NONE, 1'b0, 8'hFF);
    send_op(OP_END);
    send_op(OP_END);  // a repeated end scans the same buffer again
  endtask

  task automatic test_no_idle_stretch();
    gap_pct = 0;
    repeat (8) send_random_sequence();
    gap_pct = GAP_PCT;
  endtask

  // Hold the output long enough that a finished scan backs up into the input.
  task automatic test_output_holdoff();
    logic [15:0] id;
    id = pick_id();
    hold_pending = 1'b1;
    send_start(id, 1'b0);
    send_frame(id, 1'b0, FAULT_NONE, 1'b1, 8'h00);
    repeat (4) send_op(OP_END);
    repeat (3) send_byte(8'($urandom_range(255)));
    send_op(OP_END);
  endtask

  task automatic test_random_frames();
    while (items_sent < ITEMS_TARGET || scans_sent < MIN_SCANS) send_random_sequence();
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    rx_count     = 0;
    rx_want_id   = '0;
    rx_mode      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_no_idle_stretch();
    test_output_holdoff();
    test_random_frames();

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests including %0d end-of-reception scans; %0d results checked.",
             items_sent, scans_sent, results_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
